// ----- rtl/sct_pkg.sv -----
// Shared types and constants for the shell command tokenizer.
`timescale 1ns / 1ps

package sct_pkg;

    // Token kinds on the result channel
    localparam logic [2:0] K_CHAR = 3'd0;
    localparam logic [2:0] K_WEND = 3'd1;
    localparam logic [2:0] K_AND  = 3'd2;
    localparam logic [2:0] K_OR   = 3'd3;
    localparam logic [2:0] K_PIPE = 3'd4;
    localparam logic [2:0] K_BG   = 3'd5;
    localparam logic [2:0] K_EOL  = 3'd6;

    // Lexer modes; codes above M_ESCAPE behave as default
    localparam logic [2:0] M_DEFAULT = 3'd0;
    localparam logic [2:0] M_WORD    = 3'd1;
    localparam logic [2:0] M_SQUOTE  = 3'd2;
    localparam logic [2:0] M_DQUOTE  = 3'd3;
    localparam logic [2:0] M_ESCAPE  = 3'd4;

    // Pending operator codes
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_AMP  = 2'd1;
    localparam logic [1:0] OP_BAR  = 2'd2;

    // Special bytes
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Most tokens one byte can produce
    localparam int MAX_TOK = 4;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic       last;
    } token_t;

endpackage

// ----- rtl/sct_if.sv -----
// Request channel interfaces: command bytes in, tokens out.
`timescale 1ns / 1ps

interface sct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_line;

    modport source (output valid, output char_in, output end_of_line, input ready);
    modport sink   (input valid, input char_in, input end_of_line, output ready);
endinterface

interface sct_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] char_out;
    logic       last;

    modport source (output valid, output kind, output char_out, output last, input ready);
    modport sink   (input valid, input kind, input char_out, input last, output ready);
endinterface

// ----- rtl/shell_command_tokenizer.sv -----
// Top level of the shell command tokenizer: lexer and token queue.
`timescale 1ns / 1ps

// Streaming lexer for a shell command line.
// cmd carries one byte per request with an end-of-line flag; tok carries
// tokens (word char, word end, AND_IF, OR_IF, PIPE, BACKGROUND, end of line),
// with last set on the final token caused by a byte.
// A request is lexed in the cycle it is accepted; its tokens (zero to four)
// land in a four-slot token register and leave one per cycle while tok.ready
// is high, the first in the cycle after acceptance.
// Throughput: one byte per cycle while bytes yield at most one token and
// tok.ready is high; a byte yielding several tokens holds off the next byte
// until its last token is leaving. cmd.ready stays high while the token
// register is empty or is handing off its last token, so the next byte is
// taken in the same cycle that token leaves. When tok.ready is low the queued
// tokens hold and cmd.ready drops whenever any token is waiting.
// Reset (rst_n low, asynchronous) empties the token register and returns the
// lexer to default mode, no open word, no pending operator.
module shell_command_tokenizer
    import sct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sct_in_if.sink     cmd,
    sct_out_if.source  tok
);

    localparam int CNT_W = $clog2(MAX_TOK + 1);

    logic [2:0]       mode_reg, mode_next;
    logic             word_open_reg, word_open_next;
    logic [1:0]       pend_reg, pend_next;
    token_t           buf_reg [MAX_TOK];
    token_t           buf_next [MAX_TOK];
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    token_t           tok_v [MAX_TOK];
    logic [CNT_W-1:0] n_v;
    logic             consumed;
    logic             do_default;
    logic [7:0]       c;
    logic             accept;
    logic             pop;

    assign c      = cmd.char_in;
    assign pop    = tok.valid && tok.ready;
    assign cmd.ready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && tok.ready);
    assign accept = cmd.valid && cmd.ready;

    // Lex one byte: build its token list and the next lexer state
    always_comb
    begin
        for (int i = 0; i < MAX_TOK; i++)
        begin
            tok_v[i] = '0;
        end
        n_v            = '0;
        consumed       = 1'b0;
        do_default     = 1'b0;
        mode_next      = mode_reg;
        word_open_next = word_open_reg;
        pend_next      = OP_NONE;

        // resolve the operator waiting on lookahead
        if (pend_reg == OP_AMP)
        begin
            if (c == CH_AMP)
            begin
                tok_v[n_v[1:0]].kind = K_AND;
                consumed = 1'b1;
            end
            else
            begin
                tok_v[n_v[1:0]].kind = K_BG;
            end
            n_v = n_v + CNT_W'(1);
        end
        else if (pend_reg == OP_BAR)
        begin
            if (c == CH_BAR)
            begin
                tok_v[n_v[1:0]].kind = K_OR;
                consumed = 1'b1;
            end
            else
            begin
                tok_v[n_v[1:0]].kind = K_PIPE;
            end
            n_v = n_v + CNT_W'(1);
        end

        if (!consumed)
        begin
            case (mode_reg)
                M_WORD:
                begin
                    if (c == CH_SPACE)
                    begin
                        if (word_open_next)
                        begin
                            tok_v[n_v[1:0]].kind = K_WEND;
                            n_v = n_v + CNT_W'(1);
                            word_open_next = 1'b0;
                        end
                        mode_next = M_DEFAULT;
                    end
                    else if (c == CH_AMP || c == CH_BAR)
                    begin
                        do_default = 1'b1;
                    end
                    else if (c == CH_SQUOTE)
                    begin
                        mode_next = M_SQUOTE;
                    end
                    else if (c == CH_DQUOTE)
                    begin
                        mode_next = M_DQUOTE;
                    end
                    else
                    begin
                        tok_v[n_v[1:0]].kind = K_CHAR;
                        tok_v[n_v[1:0]].ch   = c;
                        n_v = n_v + CNT_W'(1);
                        word_open_next = 1'b1;
                    end
                end
                M_SQUOTE, M_DQUOTE:
                begin
                    if ((mode_reg == M_SQUOTE && c == CH_SQUOTE) ||
                        (mode_reg == M_DQUOTE && c == CH_DQUOTE))
                    begin
                        mode_next = M_WORD;
                    end
                    else
                    begin
                        tok_v[n_v[1:0]].kind = K_CHAR;
                        tok_v[n_v[1:0]].ch   = c;
                        n_v = n_v + CNT_W'(1);
                        word_open_next = 1'b1;
                    end
                end
                M_ESCAPE:
                begin
                    tok_v[n_v[1:0]].kind = K_CHAR;
                    tok_v[n_v[1:0]].ch   = c;
                    n_v = n_v + CNT_W'(1);
                    word_open_next = 1'b1;
                    mode_next = M_DEFAULT;
                end
                default:
                begin
                    do_default = 1'b1;
                end
            endcase
        end

        // default-mode handling, also reached from word mode on an operator
        if (do_default)
        begin
            if (c == CH_SQUOTE)
            begin
                mode_next = M_SQUOTE;
            end
            else if (c == CH_DQUOTE)
            begin
                mode_next = M_DQUOTE;
            end
            else if (c == CH_BSLASH)
            begin
                mode_next = M_ESCAPE;
            end
            else if (c == CH_AMP || c == CH_BAR)
            begin
                if (word_open_next)
                begin
                    tok_v[n_v[1:0]].kind = K_WEND;
                    n_v = n_v + CNT_W'(1);
                    word_open_next = 1'b0;
                end
                pend_next = (c == CH_AMP) ? OP_AMP : OP_BAR;
                mode_next = M_DEFAULT;
            end
            else
            begin
                if (c != CH_SPACE)
                begin
                    tok_v[n_v[1:0]].kind = K_CHAR;
                    tok_v[n_v[1:0]].ch   = c;
                    n_v = n_v + CNT_W'(1);
                    word_open_next = 1'b1;
                end
                mode_next = M_WORD;
            end
        end

        // end of line: flush operator and word, mark the line, reset state
        if (cmd.end_of_line)
        begin
            if (pend_next == OP_AMP)
            begin
                tok_v[n_v[1:0]].kind = K_BG;
                n_v = n_v + CNT_W'(1);
            end
            else if (pend_next == OP_BAR)
            begin
                tok_v[n_v[1:0]].kind = K_PIPE;
                n_v = n_v + CNT_W'(1);
            end
            if (word_open_next)
            begin
                tok_v[n_v[1:0]].kind = K_WEND;
                n_v = n_v + CNT_W'(1);
            end
            tok_v[n_v[1:0]].kind = K_EOL;
            n_v = n_v + CNT_W'(1);
            mode_next      = M_DEFAULT;
            word_open_next = 1'b0;
            pend_next      = OP_NONE;
        end

        // flag the final token of this byte
        for (int i = 0; i < MAX_TOK; i++)
        begin
            tok_v[i].last = (n_v == CNT_W'(i + 1));
        end
    end

    // Token queue: load on accept, shift down on each departure
    always_comb
    begin
        for (int i = 0; i < MAX_TOK; i++)
        begin
            buf_next[i] = buf_reg[i];
        end
        cnt_next = cnt_reg;
        if (accept)
        begin
            for (int i = 0; i < MAX_TOK; i++)
            begin
                buf_next[i] = tok_v[i];
            end
            cnt_next = n_v;
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_TOK - 1; i++)
            begin
                buf_next[i] = buf_reg[i + 1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Lexer state and queue count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_DEFAULT;
            word_open_reg <= 1'b0;
            pend_reg      <= OP_NONE;
            cnt_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg      <= mode_next;
                word_open_reg <= word_open_next;
                pend_reg      <= pend_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Token payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_TOK; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
    end

    assign tok.valid    = (cnt_reg != '0);
    assign tok.kind     = buf_reg[0].kind;
    assign tok.char_out = buf_reg[0].ch;
    assign tok.last     = buf_reg[0].last;

    // Checks
    a_tok_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && n_v != '0) |=> tok.valid)
        else $error("accepted byte with tokens left the queue empty");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        tok.valid |-> (tok.last == (cnt_reg == CNT_W'(1))))
        else $error("last flag not on final queued token");

    a_eol_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.end_of_line) |=>
            (mode_reg == M_DEFAULT && !word_open_reg && pend_reg == OP_NONE))
        else $error("lexer state not cleared after end of line");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tok.valid && tok.kind != K_CHAR) |-> (tok.char_out == 8'h00))
        else $error("non-character token carries a byte");

endmodule
